FILE: hdl/taf_pkg.sv
// taf_pkg: opcodes and stage payload types for the thumb alu flags block
// used by the decode, execute, flags and top modules of the block; depends on nothing
`default_nettype none

package taf_pkg;

  localparam logic [3:0] OP_AND = 4'b0000;
  localparam logic [3:0] OP_EOR = 4'b0001;
  localparam logic [3:0] OP_LSL = 4'b0010;
  localparam logic [3:0] OP_LSR = 4'b0011;
  localparam logic [3:0] OP_ASR = 4'b0100;
  localparam logic [3:0] OP_ADC = 4'b0101;
  localparam logic [3:0] OP_SBC = 4'b0110;
  localparam logic [3:0] OP_ROR = 4'b0111;
  localparam logic [3:0] OP_TST = 4'b1000;
  localparam logic [3:0] OP_NEG = 4'b1001;
  localparam logic [3:0] OP_CMP = 4'b1010;
  localparam logic [3:0] OP_CMN = 4'b1011;
  localparam logic [3:0] OP_ORR = 4'b1100;
  localparam logic [3:0] OP_MUL = 4'b1101;
  localparam logic [3:0] OP_BIC = 4'b1110;
  localparam logic [3:0] OP_MVN = 4'b1111;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SHAMT_W = 8;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  b;
    logic [WORD_W-1:0]  add_x;
    logic [WORD_W-1:0]  add_y;
    logic               add_cin;
    logic [WORD_W-1:0]  mul_lo;
    logic [15:0]        mul_hi;
    logic [SHAMT_W-1:0] shamt;
    logic               amt_zero;
    logic               amt_small;
    logic               amt_32;
    logic               cin;
    logic               vin;
    logic               wb;
  } dec_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              wb;
    logic              c;
    logic              v;
  } exe_t;

endpackage

`default_nettype wire

FILE: hdl/taf_if.sv
// taf_in_if / taf_out_if: valid-ready channels for operations and results
// depends on nothing
`default_nettype none

interface taf_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [31:0] first_operand;
  logic [31:0] second_operand;
  logic        carry_in;
  logic        overflow_in;

  modport source (output valid, opcode, first_operand, second_operand, carry_in,
                  overflow_in, input ready);
  modport sink (input valid, opcode, first_operand, second_operand, carry_in,
                overflow_in, output ready);
endinterface

interface taf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        write_back;
  logic        negative_flag;
  logic        zero_flag;
  logic        carry_out;
  logic        overflow_out;

  modport source (output valid, result, write_back, negative_flag, zero_flag,
                  carry_out, overflow_out, input ready);
  modport sink (input valid, result, write_back, negative_flag, zero_flag,
                carry_out, overflow_out, output ready);
endinterface

`default_nettype wire

FILE: hdl/thumb_alu_flags_top.sv
// thumb_alu_flags_top: three-stage pipelined thumb alu with nzcv flag generation
// depends on taf_pkg, taf_if, taf_decode, taf_execute, taf_flags
//
//   channel | direction | transaction
//   in_ch   | sink      | opcode, first_operand, second_operand, carry_in, overflow_in
//   out_ch  | source    | result, write_back, negative_flag, zero_flag, carry_out,
//           |           | overflow_out
//
// one transaction per cycle sustained while out_ch is ready
// stages: decode (operand set-up, partial products), execute, flags register
// each stage holds its item under back-pressure and takes a new one when its successor moves
// synchronous reset empties all three stages; there is no other state
`default_nettype none

module thumb_alu_flags_top
  import taf_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  taf_in_if.sink   in_ch,
  taf_out_if.source out_ch
);

  logic dec_valid, dec_ready;
  dec_t dec;
  logic exe_valid, exe_ready;
  exe_t exe;

  taf_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_ch.valid),
    .ready_o  (in_ch.ready),
    .opcode_i (in_ch.opcode),
    .a_i      (in_ch.first_operand),
    .b_i      (in_ch.second_operand),
    .cin_i    (in_ch.carry_in),
    .vin_i    (in_ch.overflow_in),
    .valid_o  (dec_valid),
    .ready_i  (dec_ready),
    .dec_o    (dec)
  );

  taf_execute u_execute (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (exe_valid),
    .ready_i (exe_ready),
    .exe_o   (exe)
  );

  taf_flags u_flags (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (exe_valid),
    .ready_o  (exe_ready),
    .exe_i    (exe),
    .valid_o  (out_ch.valid),
    .ready_i  (out_ch.ready),
    .result_o (out_ch.result),
    .wb_o     (out_ch.write_back),
    .n_o      (out_ch.negative_flag),
    .z_o      (out_ch.zero_flag),
    .c_o      (out_ch.carry_out),
    .v_o      (out_ch.overflow_out)
  );

endmodule

`default_nettype wire

FILE: hdl/taf_decode.sv
// taf_decode: first pipeline stage, adder operand set-up, shift amount classes
// and multiplier partial products; depends on taf_pkg
`default_nettype none

module taf_decode
  import taf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic        cin_i,
  input  wire logic        vin_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output dec_t             dec_o
);

  logic vld_r, vld_nxt;
  dec_t dec_r, dec_nxt;

  assign ready_o = !vld_r || ready_i;

  always_comb begin
    dec_nxt           = '0;
    dec_nxt.opcode    = opcode_i;
    dec_nxt.a         = a_i;
    dec_nxt.b         = b_i;
    dec_nxt.cin       = cin_i;
    dec_nxt.vin       = vin_i;
    dec_nxt.shamt     = b_i[SHAMT_W-1:0];
    dec_nxt.amt_zero  = (b_i[SHAMT_W-1:0] == '0);
    dec_nxt.amt_small = (b_i[SHAMT_W-1:5] == '0);
    dec_nxt.amt_32    = (b_i[SHAMT_W-1:0] == SHAMT_W'(WORD_W));
    dec_nxt.add_x     = a_i;
    dec_nxt.add_y     = b_i;
    dec_nxt.add_cin   = 1'b0;
    dec_nxt.mul_lo    = a_i * {16'b0, b_i[15:0]};
    dec_nxt.mul_hi    = a_i[15:0] * b_i[31:16];
    dec_nxt.wb        = 1'b1;
    unique case (opcode_i) inside
      OP_ADC: dec_nxt.add_cin = cin_i;
      OP_SBC: begin
        dec_nxt.add_y   = ~b_i;
        dec_nxt.add_cin = cin_i;
      end
      OP_NEG: begin
        dec_nxt.add_x   = '0;
        dec_nxt.add_y   = ~b_i;
        dec_nxt.add_cin = 1'b1;
      end
      OP_CMP: begin
        dec_nxt.add_y   = ~b_i;
        dec_nxt.add_cin = 1'b1;
        dec_nxt.wb      = 1'b0;
      end
      OP_TST, OP_CMN: dec_nxt.wb = 1'b0;
      default: ;
    endcase
  end

  assign vld_nxt = ready_o ? valid_i : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      dec_r <= dec_nxt;
    end
  end

  assign valid_o = vld_r;
  assign dec_o   = dec_r;

endmodule

`default_nettype wire

FILE: hdl/taf_execute.sv
// taf_execute: second pipeline stage, adder, barrel shifter, logic and product sum
// depends on taf_pkg
`default_nettype none

module taf_execute
  import taf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire dec_t dec_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output exe_t      exe_o
);

  logic vld_r, vld_nxt;
  exe_t exe_r, exe_nxt;

  logic [4:0]        sh;
  logic [32:0]       sum;
  logic [32:0]       lsl_w;
  logic [32:0]       lsr_w;
  logic [32:0]       asr_w;
  logic [63:0]       ror_w;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic              add_v;

  assign ready_o = !vld_r || ready_i;

  assign a     = dec_i.a;
  assign b     = dec_i.b;
  assign sh    = dec_i.shamt[4:0];
  assign sum   = {1'b0, dec_i.add_x} + {1'b0, dec_i.add_y} + {32'b0, dec_i.add_cin};
  assign add_v = ~(dec_i.add_x[31] ^ dec_i.add_y[31]) & (dec_i.add_x[31] ^ sum[31]);
  assign lsl_w = {1'b0, a} << sh;
  assign lsr_w = {a, 1'b0} >> sh;
  assign asr_w = 33'($signed({a, 1'b0}) >>> sh);
  assign ror_w = {a, a} >> sh;
  assign prod  = dec_i.mul_lo + {dec_i.mul_hi, 16'b0};

  always_comb begin
    exe_nxt        = '0;
    exe_nxt.wb     = dec_i.wb;
    exe_nxt.c      = dec_i.cin;
    exe_nxt.v      = dec_i.vin;
    exe_nxt.result = a;
    unique case (dec_i.opcode)
      OP_AND, OP_TST: exe_nxt.result = a & b;
      OP_EOR: exe_nxt.result = a ^ b;
      OP_ORR: exe_nxt.result = a | b;
      OP_BIC: exe_nxt.result = a & ~b;
      OP_MUL: exe_nxt.result = prod;
      OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN: begin
        exe_nxt.result = sum[31:0];
        exe_nxt.c      = sum[32];
        exe_nxt.v      = add_v;
      end
      OP_LSL: begin
        if (dec_i.amt_zero) begin
          exe_nxt.result = a;
        end else if (dec_i.amt_small) begin
          exe_nxt.result = lsl_w[31:0];
          exe_nxt.c      = lsl_w[32];
        end else begin
          exe_nxt.result = '0;
          exe_nxt.c      = dec_i.amt_32 & a[0];
        end
      end
      OP_LSR: begin
        if (dec_i.amt_zero) begin
          exe_nxt.result = a;
        end else if (dec_i.amt_small) begin
          exe_nxt.result = lsr_w[32:1];
          exe_nxt.c      = lsr_w[0];
        end else begin
          exe_nxt.result = '0;
          exe_nxt.c      = dec_i.amt_32 & a[31];
        end
      end
      OP_ASR: begin
        if (dec_i.amt_zero) begin
          exe_nxt.result = a;
        end else if (dec_i.amt_small) begin
          exe_nxt.result = asr_w[32:1];
          exe_nxt.c      = asr_w[0];
        end else begin
          exe_nxt.result = {WORD_W{a[31]}};
          exe_nxt.c      = a[31];
        end
      end
      OP_ROR: begin
        exe_nxt.result = ror_w[31:0];
        if (!dec_i.amt_zero) begin
          exe_nxt.c = ror_w[31];
        end
      end
      default: exe_nxt.result = ~b;
    endcase
  end

  assign vld_nxt = ready_o ? valid_i : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      exe_r <= exe_nxt;
    end
  end

  assign valid_o = vld_r;
  assign exe_o   = exe_r;

endmodule

`default_nettype wire

FILE: hdl/taf_flags.sv
// taf_flags: last pipeline stage, n and z flags and the result output register
// depends on taf_pkg
`default_nettype none

module taf_flags
  import taf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   valid_i,
  output logic        ready_o,
  input  wire exe_t   exe_i,
  output logic        valid_o,
  input  wire logic   ready_i,
  output logic [31:0] result_o,
  output logic        wb_o,
  output logic        n_o,
  output logic        z_o,
  output logic        c_o,
  output logic        v_o
);

  logic              vld_r, vld_nxt;
  logic [WORD_W-1:0] result_r;
  logic              wb_r, n_r, z_r, c_r, v_r;

  assign ready_o = !vld_r || ready_i;
  assign vld_nxt = ready_o ? valid_i : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      result_r <= exe_i.result;
      wb_r     <= exe_i.wb;
      n_r      <= exe_i.result[WORD_W-1];
      z_r      <= (exe_i.result == '0);
      c_r      <= exe_i.c;
      v_r      <= exe_i.v;
    end
  end

  assign valid_o  = vld_r;
  assign result_o = result_r;
  assign wb_o     = wb_r;
  assign n_o      = n_r;
  assign z_o      = z_r;
  assign c_o      = c_r;
  assign v_o      = v_r;

endmodule

`default_nettype wire

FILE: hdl/taf_checker.sv
// taf_checker: port-level assertions for thumb_alu_flags_top, bound to the top level
// depends on thumb_alu_flags_top and taf_if
`default_nettype none

module taf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result,
  input wire logic        out_negative_flag,
  input wire logic        out_zero_flag
);

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_nz_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_flag == (out_result == 32'd0)) &&
                  (out_negative_flag == out_result[31]))
    else $error("n or z flag disagrees with result");

  // with the sink taking, a transaction reaches the output through the decode, execute and flags registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready ##1 out_ready ##1 out_ready) |=> out_valid)
    else $error("transaction lost in pipeline");

endmodule

bind thumb_alu_flags_top taf_checker u_taf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_result        (out_ch.result),
  .out_negative_flag (out_ch.negative_flag),
  .out_zero_flag     (out_ch.zero_flag)
);

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking bench for thumb_alu_flags_top, driving operations on in_ch and
// comparing every out_ch transaction with a locally computed alu result and nzcv flags
// depends on taf_pkg, taf_if and thumb_alu_flags_top
`timescale 1ns / 100ps

module tb_top;
  import taf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] result;
    logic        write_back;
    logic        negative_flag;
    logic        zero_flag;
    logic        carry_out;
    logic        overflow_out;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n;

  taf_in_if  in_if ();
  taf_out_if out_if ();

  thumb_alu_flags_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  alu_result_t alu_expected_q[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  bit          source_idle_on = 1'b1;
  int          burst_left = 0;

  bit          sink_stall_on = 1'b1;
  int          hold_request = 0;
  int          hold_left = 0;
  logic [15:0] stall_pattern = 16'hffff;
  logic [3:0]  pattern_pos = 4'd0;

  always #5 clk = ~clk;

  function automatic alu_result_t predict_alu(input logic [3:0] op, input logic [31:0] a,
                                              input logic [31:0] b, input logic cin,
                                              input logic vin);
    alu_result_t res;
    logic [7:0]  amt;
    logic [4:0]  rot;
    logic [32:0] wide;
    logic [31:0] r;
    logic        c;
    logic        v;
    logic        wb;
    amt = b[7:0];
    r   = '0;
    c   = cin;
    v   = vin;
    wb  = 1'b1;
    case (op)
      OP_AND: r = a & b;
      OP_EOR: r = a ^ b;
      OP_LSL: begin
        if (amt == 0) begin
          r = a;
        end else if (amt < 32) begin
          c = a[32 - amt];
          r = a << amt;
        end else if (amt == 32) begin
          c = a[0];
          r = '0;
        end else begin
          c = 1'b0;
          r = '0;
        end
      end
      OP_LSR: begin
        if (amt == 0) begin
          r = a;
        end else if (amt < 32) begin
          c = a[amt - 1];
          r = a >> amt;
        end else if (amt == 32) begin
          c = a[31];
          r = '0;
        end else begin
          c = 1'b0;
          r = '0;
        end
      end
      OP_ASR: begin
        if (amt == 0) begin
          r = a;
        end else if (amt < 32) begin
          c = a[amt - 1];
          r = $signed(a) >>> amt;
        end else begin
          c = a[31];
          r = {32{a[31]}};
        end
      end
      OP_ADC: begin
        wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        r = wide[31:0];
        c = wide[32];
        v = (a[31] ^ r[31]) & (b[31] ^ r[31]);
      end
      OP_SBC: begin
        wide = {1'b0, a} + {1'b0, ~b} + {32'd0, cin};
        r = wide[31:0];
        c = wide[32];
        v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
      end
      OP_ROR: begin
        rot = amt[4:0];
        if (amt == 0) begin
          r = a;
        end else if (rot == 0) begin
          r = a;
          c = a[31];
        end else begin
          c = a[rot - 1];
          r = (a >> rot) | (a << (32 - rot));
        end
      end
      OP_TST: begin
        r  = a & b;
        wb = 1'b0;
      end
      OP_NEG: begin
        r = 32'd0 - b;
        c = (b == 32'd0);
        v = (b == 32'h8000_0000);
      end
      OP_CMP: begin
        r  = a - b;
        c  = (a >= b);
        v  = (a[31] ^ b[31]) & (a[31] ^ r[31]);
        wb = 1'b0;
      end
      OP_CMN: begin
        wide = {1'b0, a} + {1'b0, b};
        r  = wide[31:0];
        c  = wide[32];
        v  = (a[31] ^ r[31]) & (b[31] ^ r[31]);
        wb = 1'b0;
      end
      OP_ORR: r = a | b;
      OP_MUL: r = a * b;
      OP_BIC: r = a & ~b;
      default: r = ~b;
    endcase
    res.result        = r;
    res.write_back    = wb;
    res.negative_flag = r[31];
    res.zero_flag     = (r == 32'd0);
    res.carry_out     = c;
    res.overflow_out  = v;
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_shift_operand();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w[7:0] = 8'd0;
      1: w[7:0] = 8'd1;
      2: w[7:0] = 8'd31 + 8'($urandom_range(0, 2));
      3: w[7:0] = 8'($urandom_range(1, 7)) << 5;
      4: w[7:0] = 8'($urandom_range(0, 40));
      5: w[7:0] = 8'($urandom_range(0, 31));
      default: w[7:0] = 8'($urandom_range(0, 255));
    endcase
    return w;
  endfunction

  task automatic send_op(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                         input logic cin, input logic vin);
    int gap;
    if (source_idle_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_if.valid          <= 1'b1;
    in_if.opcode         <= op;
    in_if.first_operand  <= a;
    in_if.second_operand <= b;
    in_if.carry_in       <= cin;
    in_if.overflow_in    <= vin;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic test_directed_logic();
    send_op(OP_AND, 32'hffff_ffff, 32'h8000_0001, 1'b1, 1'b1);
    send_op(OP_EOR, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b1);
    send_op(OP_ORR, 32'd0, 32'd0, 1'b1, 1'b0);
    send_op(OP_BIC, 32'hffff_ffff, 32'h0000_ffff, 1'b0, 1'b0);
    send_op(OP_MVN, 32'h1234_5678, 32'h7fff_ffff, 1'b1, 1'b1);
    send_op(OP_TST, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
  endtask

  task automatic test_directed_shifts();
    send_op(OP_LSL, 32'hdead_beef, 32'hffff_ff00, 1'b1, 1'b1);
    send_op(OP_LSL, 32'h8000_0001, 32'd1, 1'b0, 1'b0);
    send_op(OP_LSL, 32'h0000_0001, 32'd32, 1'b0, 1'b1);
    send_op(OP_LSL, 32'hffff_ffff, 32'd33, 1'b1, 1'b0);
    send_op(OP_LSR, 32'h8000_0000, 32'd32, 1'b0, 1'b0);
    send_op(OP_LSR, 32'hffff_ffff, 32'd31, 1'b0, 1'b1);
    send_op(OP_ASR, 32'h8000_0000, 32'd32, 1'b0, 1'b0);
    send_op(OP_ASR, 32'h8765_4321, 32'd255, 1'b0, 1'b1);
    send_op(OP_ROR, 32'h8000_0001, 32'd64, 1'b0, 1'b0);
    send_op(OP_ROR, 32'h0000_0003, 32'h0000_0121, 1'b0, 1'b1);
  endtask

  task automatic test_directed_arith();
    send_op(OP_ADC, 32'h7fff_ffff, 32'd0, 1'b1, 1'b0);
    send_op(OP_ADC, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    send_op(OP_SBC, 32'h8000_0000, 32'd0, 1'b0, 1'b0);
    send_op(OP_NEG, 32'h5555_5555, 32'd0, 1'b0, 1'b1);
    send_op(OP_NEG, 32'd0, 32'h8000_0000, 1'b1, 1'b0);
    send_op(OP_CMP, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1);
    send_op(OP_CMN, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    send_op(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
  endtask

  task automatic test_random_ops(input int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      op = 4'($urandom_range(0, 15));
      send_op(op, rand_word(),
              (op inside {OP_LSL, OP_LSR, OP_ASR, OP_ROR}) ? rand_shift_operand() : rand_word(),
              1'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic test_shift_amounts(input int count);
    logic [3:0] shift_ops[4];
    shift_ops = '{OP_LSL, OP_LSR, OP_ASR, OP_ROR};
    for (int i = 0; i < count; i++) begin
      send_op(shift_ops[$urandom_range(0, 3)], rand_word(), rand_shift_operand(),
              1'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic test_arith_corners(input int count);
    logic [3:0]  arith_ops[5];
    logic [31:0] a;
    logic [31:0] b;
    arith_ops = '{OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN};
    for (int i = 0; i < count; i++) begin
      a = rand_word();
      case ($urandom_range(0, 4))
        0: b = a;
        1: b = ~a;
        2: b = a + 32'd1;
        3: b = a - 32'd1;
        default: b = rand_word();
      endcase
      send_op(arith_ops[$urandom_range(0, 4)], a, b, 1'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic test_back_pressure(input int count);
    hold_request = $urandom_range(200, 400);
    test_random_ops(count / 2);
    hold_request = $urandom_range(100, 300);
    test_random_ops(count - count / 2);
  endtask

  task automatic test_full_rate(input int count);
    source_idle_on = 1'b0;
    sink_stall_on  = 1'b0;
    test_random_ops(count);
    source_idle_on = 1'b1;
    sink_stall_on  = 1'b1;
  endtask

  // receiver: hold-off, then always ready or a 16-bit stall pattern redrawn on wrap
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (!sink_stall_on) begin
      out_if.ready <= 1'b1;
    end else begin
      if (pattern_pos == 4'd0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hffff;
          1: stall_pattern = 16'($urandom());
          2: stall_pattern = 16'($urandom() | $urandom());
          default: stall_pattern = 16'($urandom() & $urandom());
        endcase
      end
      out_if.ready <= stall_pattern[pattern_pos];
      pattern_pos = pattern_pos + 4'd1;
    end
  end

  // scoreboard: queue predictions on input transactions, check output transactions
  always @(posedge clk) begin
    alu_result_t exp_res;
    alu_result_t act_res;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        alu_expected_q.push_back(predict_alu(in_if.opcode, in_if.first_operand,
                                             in_if.second_operand, in_if.carry_in,
                                             in_if.overflow_in));
      end
      if (out_if.valid && out_if.ready) begin
        act_res.result        = out_if.result;
        act_res.write_back    = out_if.write_back;
        act_res.negative_flag = out_if.negative_flag;
        act_res.zero_flag     = out_if.zero_flag;
        act_res.carry_out     = out_if.carry_out;
        act_res.overflow_out  = out_if.overflow_out;
        if (alu_expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result res=%h wb=%b nzcv=%b%b%b%b", $realtime,
                     act_res.result, act_res.write_back, act_res.negative_flag,
                     act_res.zero_flag, act_res.carry_out, act_res.overflow_out);
          end
        end else begin
          exp_res = alu_expected_q.pop_front();
          if (act_res.result !== exp_res.result || act_res.write_back !== exp_res.write_back ||
              act_res.negative_flag !== exp_res.negative_flag ||
              act_res.zero_flag !== exp_res.zero_flag ||
              act_res.carry_out !== exp_res.carry_out ||
              act_res.overflow_out !== exp_res.overflow_out) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: exp res=%h wb=%b nzcv=%b%b%b%b got res=%h wb=%b nzcv=%b%b%b%b",
                       $realtime, exp_res.result, exp_res.write_back, exp_res.negative_flag,
                       exp_res.zero_flag, exp_res.carry_out, exp_res.overflow_out,
                       act_res.result, act_res.write_back, act_res.negative_flag,
                       act_res.zero_flag, act_res.carry_out, act_res.overflow_out);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.opcode         = OP_AND;
    in_if.first_operand  = '0;
    in_if.second_operand = '0;
    in_if.carry_in       = 1'b0;
    in_if.overflow_in    = 1'b0;
    out_if.ready         = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_logic();
    test_directed_shifts();
    test_directed_arith();
    test_random_ops(700);
    test_shift_amounts(300);
    test_arith_corners(300);
    test_back_pressure(200);
    test_full_rate(200);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (alu_expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/taf_pkg.sv
hdl/taf_if.sv
hdl/taf_decode.sv
hdl/taf_execute.sv
hdl/taf_flags.sv
hdl/thumb_alu_flags_top.sv
hdl/taf_checker.sv
test/tb_top.sv
